>>> design/lcrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcrm_pkg: shared types and constants
// Field widths, request codes, register indexes and the divider response
// used by the limited counter with rate meter.
// ----------------------------------------------------------------------------
package lcrm_pkg;

  localparam int unsigned COUNT_W    = 48;
  localparam int unsigned RATE_W     = 32;
  localparam int unsigned FILL_W     = 6;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned MS_PER_S   = 1000;
  localparam int unsigned MS_PER_S_W = 10;
  // dividend holds delta count times 1000
  localparam int unsigned DIVIDEND_W = COUNT_W + MS_PER_S_W;

  localparam int unsigned DEF_HISTORY_DEPTH = 50;

  typedef enum logic [REQ_W-1:0] {
    REQ_PULSE = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_TIME  = 2'd2,
    REQ_START = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIMIT  = 2'd0,
    CFG_OFFSET = 2'd1,
    CFG_BASE   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic              done;
    logic [RATE_W-1:0] quotient;
  } div_rsp_t;

endpackage : lcrm_pkg
`default_nettype wire

>>> design/lcrm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcrm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lcrm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 50
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : lcrm_ram
`default_nettype wire

>>> design/lcrm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcrm_div: iterative saturating divider
// Restoring division, one quotient bit per cycle, 32-bit quotient that
// saturates to all ones when the true quotient does not fit.
// ----------------------------------------------------------------------------
module lcrm_div
  import lcrm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [COUNT_W-1:0]    divisor,
  output div_rsp_t              rsp
);

  localparam int unsigned STEP_W = $clog2(RATE_W + 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] steps;
  logic [COUNT_W-1:0] rem;
  logic [RATE_W-1:0]  low;
  logic [COUNT_W-1:0] dsr;
  logic [RATE_W-1:0]  quo;

  logic [COUNT_W-1:0] head_bits;
  logic               overflow;
  logic [COUNT_W:0]   trial;
  logic [COUNT_W-1:0] diff;
  logic               fits;

  // quotient fits in 32 bits only when the upper dividend part is below divisor
  assign head_bits = COUNT_W'(dividend[DIVIDEND_W-1:RATE_W]);
  assign overflow  = (head_bits >= divisor);
  assign trial     = {rem, low[RATE_W-1]};
  assign fits      = (trial >= {1'b0, dsr});
  // the partial remainder stays below the divisor, so the difference fits
  assign diff      = COUNT_W'(trial - {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (overflow) begin
          done <= 1'b1;
        end else begin
          busy  <= 1'b1;
          steps <= STEP_W'(RATE_W);
        end
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= head_bits;
      low <= dividend[RATE_W-1:0];
      dsr <= divisor;
      quo <= overflow ? '1 : '0;
    end else if (busy) begin
      rem <= fits ? diff : trial[COUNT_W-1:0];
      low <= {low[RATE_W-2:0], 1'b0};
      quo <= {quo[RATE_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule : lcrm_div
`default_nettype wire

>>> design/limited_counter_with_rate_meter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// limited_counter_with_rate_meter: event counter with limit and rate meter
// Counts pulses up to an optional limit, loads absolute counts, and keeps a
// ring of per-interval rates whose mean it reports.
// ----------------------------------------------------------------------------
//
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------
//  in      | in_valid / in_stall     | req_type, load_value, time_ms
//  out     | out_valid / out_stall   | count, stopped, mean_rate, history_fill
//  cfg     | cfg_write               | cfg_index, cfg_data
//
//  Sequence: pulse, load, start and non-advancing time updates go straight
//  to the result step. A first advancing time update also passes the mean
//  step. Later advancing updates pass the drop, rate, append and mean steps,
//  and may use the one 32-step divider once for the rate and once for the mean.
//  Reset: rst clears control state; the rate ring is not swept.
//  Stalls: out_stall holds the result register; the next item is accepted
//  and worked down to its result step, where it waits for the slot.
//
module limited_counter_with_rate_meter
  import lcrm_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  // input item channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [REQ_W-1:0]      req_type,
  input  logic [COUNT_W-1:0]    load_value,
  input  logic [COUNT_W-1:0]    time_ms,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COUNT_W-1:0]    count,
  output logic                  stopped,
  output logic [RATE_W-1:0]     mean_rate,
  output logic [FILL_W-1:0]     history_fill,
  // configuration writes
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COUNT_W-1:0]    cfg_data
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned EW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SW = RATE_W + EW;

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b000_0000_0001,
    ST_DROP      = 11'b000_0000_0010,
    ST_DROP_SUB  = 11'b000_0000_0100,
    ST_RATE      = 11'b000_0000_1000,
    ST_MUL       = 11'b000_0001_0000,
    ST_DIV       = 11'b000_0010_0000,
    ST_DIV_WAIT  = 11'b000_0100_0000,
    ST_APPEND    = 11'b000_1000_0000,
    ST_MEAN      = 11'b001_0000_0000,
    ST_MEAN_WAIT = 11'b010_0000_0000,
    ST_FINISH    = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration
  logic [COUNT_W-1:0] limit;
  logic [COUNT_W-1:0] offset;
  logic [COUNT_W-1:0] base;

  // counter and rate meter state
  logic [COUNT_W-1:0] count_value;
  logic [COUNT_W-1:0] prev_count;
  logic [COUNT_W-1:0] prev_time;
  logic               primed;
  logic [AW-1:0]      head;
  logic [EW-1:0]      entries;
  logic [SW-1:0]      sum;
  logic [RATE_W-1:0]  mean_value;

  // working registers of one time update
  logic [COUNT_W-1:0]    tm;
  logic [COUNT_W-1:0]    dc;
  logic [COUNT_W-1:0]    dt;
  logic [DIVIDEND_W-1:0] product;
  logic [RATE_W-1:0]     rate;

  logic accept;
  logic out_slot;
  logic rate_ok;
  logic ring_full;
  logic multi;

  logic [AW-1:0] head_inc;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail;

  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [COUNT_W-1:0]    div_divisor;
  div_rsp_t              div_rsp;

  logic [RATE_W-1:0] ram_rdata;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  assign out_slot = !out_valid || !out_stall;

  assign ring_full = (entries >= EW'(HISTORY_DEPTH));
  assign multi     = (entries > EW'(1));
  // a rate is measured only with two rates held and a count that did not fall
  assign rate_ok   = (entries >= EW'(2)) && (count_value >= prev_count);

  // ring pointers: head advances on drop, append goes to head + entries
  assign head_inc = (head == AW'(HISTORY_DEPTH - 1)) ? '0 : head + AW'(1);
  assign tail_sum = (AW + 1)'(head) + (AW + 1)'(entries);
  assign tail     = (tail_sum >= (AW + 1)'(HISTORY_DEPTH))
                  ? AW'(tail_sum - (AW + 1)'(HISTORY_DEPTH))
                  : AW'(tail_sum);

  // shared divider: rate in ST_DIV, mean in ST_MEAN
  assign div_start    = (state == ST_DIV) || ((state == ST_MEAN) && multi);
  assign div_dividend = (state == ST_DIV) ? product : DIVIDEND_W'(sum);
  assign div_divisor  = (state == ST_DIV) ? dt : COUNT_W'(entries);

  lcrm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .rsp      (div_rsp)
  );

  lcrm_ram #(
    .WIDTH (RATE_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (state == ST_APPEND),
    .waddr (tail),
    .wdata (rate),
    .raddr (head),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_FINISH;
          if (req_type == REQ_TIME && time_ms != '0 && prev_time < time_ms) begin
            state_next = primed ? ST_DROP : ST_MEAN;
          end
        end
      end
      ST_DROP:      state_next = ring_full ? ST_DROP_SUB : ST_RATE;
      ST_DROP_SUB:  state_next = ST_RATE;
      ST_RATE:      state_next = rate_ok ? ST_MUL : ST_APPEND;
      ST_MUL:       state_next = ST_DIV;
      ST_DIV:       state_next = ST_DIV_WAIT;
      ST_DIV_WAIT:  state_next = div_rsp.done ? ST_APPEND : ST_DIV_WAIT;
      ST_APPEND:    state_next = ST_MEAN;
      ST_MEAN:      state_next = multi ? ST_MEAN_WAIT : ST_FINISH;
      ST_MEAN_WAIT: state_next = div_rsp.done ? ST_FINISH : ST_MEAN_WAIT;
      ST_FINISH:    state_next = out_slot ? ST_IDLE : ST_FINISH;
      default:      state_next = ST_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      limit       <= '0;
      offset      <= '0;
      base        <= '0;
      count_value <= '0;
      prev_count  <= '0;
      prev_time   <= '0;
      primed      <= 1'b0;
      head        <= '0;
      entries     <= '0;
      sum         <= '0;
      mean_value  <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        case (cfg_index)
          CFG_LIMIT:  limit  <= cfg_data;
          CFG_OFFSET: offset <= cfg_data;
          CFG_BASE:   base   <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req_type)
              REQ_PULSE: begin
                // advance unless a nonzero limit has been reached
                if (limit == '0 || count_value < limit) begin
                  count_value <= count_value + COUNT_W'(1);
                end
              end
              REQ_LOAD: begin
                count_value <= offset + load_value - base;
              end
              REQ_TIME: begin
                if (time_ms != '0) begin
                  if (prev_time >= time_ms) begin
                    prev_time <= time_ms;
                  end else if (!primed) begin
                    prev_time <= time_ms;
                    primed    <= 1'b1;
                  end
                end
              end
              REQ_START: begin
                count_value <= '0;
                offset      <= '0;
                base        <= '0;
                prev_count  <= '0;
                primed      <= 1'b0;
                head        <= '0;
                entries     <= '0;
                sum         <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_DROP_SUB: begin
          // drop the oldest rate
          sum     <= sum - SW'(ram_rdata);
          head    <= head_inc;
          entries <= entries - EW'(1);
        end
        ST_APPEND: begin
          sum        <= sum + SW'(rate);
          entries    <= entries + EW'(1);
          prev_count <= count_value;
          prev_time  <= tm;
        end
        ST_MEAN: begin
          // with one rate or none the mean is the sum itself
          if (!multi) begin
            mean_value <= sum[RATE_W-1:0];
          end
        end
        ST_MEAN_WAIT: begin
          if (div_rsp.done) begin
            mean_value <= div_rsp.quotient;
          end
        end
        default: ;
      endcase

      if (state == ST_FINISH && out_slot) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working data and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      tm <= time_ms;
    end
    if (state == ST_RATE) begin
      dc <= count_value - prev_count;
      dt <= tm - prev_time;
      if (!rate_ok) begin
        rate <= '0;
      end
    end
    if (state == ST_MUL) begin
      product <= DIVIDEND_W'(dc) * DIVIDEND_W'(MS_PER_S);
    end
    if (state == ST_DIV_WAIT && div_rsp.done) begin
      rate <= div_rsp.quotient;
    end
    if (state == ST_FINISH && out_slot) begin
      count        <= count_value;
      stopped      <= (limit != '0) && (count_value >= limit);
      mean_rate    <= mean_value;
      history_fill <= FILL_W'(entries);
    end
  end

  // the ring never holds more rates than it has slots
  assert property (@(posedge clk) disable iff (rst)
    entries <= EW'(HISTORY_DEPTH))
    else $error("rate ring overfilled");

  // an empty ring carries no sum
  assert property (@(posedge clk) disable iff (rst)
    (entries == '0) |-> (sum == '0))
    else $error("nonzero sum with empty ring");

  // divider results only arrive while the sequencer waits for one
  assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV_WAIT || state == ST_MEAN_WAIT))
    else $error("unexpected divider result");

  // head pointer stays inside the ring
  assert property (@(posedge clk) disable iff (rst)
    (AW + 1)'(head) < (AW + 1)'(HISTORY_DEPTH))
    else $error("ring head out of range");

endmodule : limited_counter_with_rate_meter
`default_nettype wire
